[hw/rtl/gbts_pkg.sv]
package gbts_pkg;

   // storage geometry
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int GAP_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int MODE_W   = 2;
   localparam int POS_W    = 11;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;

   // width used for position against gap / length compares
   localparam int CMP_W = (GAP_W > POS_W) ? GAP_W : POS_W;

   // request modes
   localparam logic [MODE_W-1:0] MODE_READ   = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_DELETE = MODE_W'(2);

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_READ,
      S_MOVE,
      S_SHIFT,
      S_EDIT,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic accept;
      logic decide;
      logic read;
      logic move_read;
      logic move_write;
      logic edit;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              error;
      logic              need_left;
      logic              need_right;
   } dp_stat_type;

endpackage

[hw/rtl/gbts_ram.sv]
module gbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gbts_ctrl.sv]
module gbts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  gbts_pkg::dp_stat_type stat,
   output gbts_pkg::ctrl_cmd_type cmd,
   output logic                 busy
);
   import gbts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (stat.error) state_in = S_RESPOND;
            else if (stat.mode == MODE_READ) state_in = S_READ;
            else if (stat.mode == MODE_INSERT || stat.mode == MODE_DELETE) state_in = S_MOVE;
            else state_in = S_RESPOND;
         end
         S_READ:    state_in = S_RESPOND;
         S_MOVE: begin
            if (stat.need_left || stat.need_right) state_in = S_SHIFT;
            else state_in = S_EDIT;
         end
         S_SHIFT:   state_in = S_MOVE;
         S_EDIT:    state_in = S_RESPOND;
         S_RESPOND: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:    cmd.accept     = start;
         S_DECIDE:  cmd.decide     = 1'b1;
         S_READ:    cmd.read       = 1'b1;
         S_MOVE:    cmd.move_read  = stat.need_left || stat.need_right;
         S_SHIFT:   cmd.move_write = 1'b1;
         S_EDIT:    cmd.edit       = 1'b1;
         S_RESPOND: cmd.respond    = 1'b1;
         default:   cmd            = '0;
      endcase
   end

endmodule

[hw/rtl/gbts_dp.sv]
module gbts_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  gbts_pkg::ctrl_cmd_type          cmd,
   output gbts_pkg::dp_stat_type           stat,
   input  logic [gbts_pkg::MODE_W-1:0]     req_mode,
   input  logic [gbts_pkg::POS_W-1:0]      req_position,
   input  logic [gbts_pkg::CHAR_W-1:0]     req_char_in,
   output logic                            rsp_valid,
   output logic [gbts_pkg::CHAR_W-1:0]     rsp_char_out,
   output logic [gbts_pkg::POS_W-1:0]      rsp_length,
   output logic [gbts_pkg::STATUS_W-1:0]   rsp_status
);
   import gbts_pkg::*;

   // latched request
   logic [MODE_W-1:0]   mode_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [STATUS_W-1:0] status_hold_ff;

   // gap pointers
   logic [GAP_W-1:0] gap_begin_ff, gap_begin_in;
   logic [GAP_W-1:0] gap_finish_ff, gap_finish_in;

   // response registers
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [POS_W-1:0]    rsp_length_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // ram port signals
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [CHAR_W-1:0] ram_wr_data, ram_rd_data;

   logic [GAP_W-1:0]    len;
   logic [CMP_W-1:0]    pos_cmp, len_cmp, begin_cmp, read_idx;
   logic [GAP_W-1:0]    begin_dec, finish_dec;
   logic                finish_at_end;
   logic [STATUS_W-1:0] status_now;

   assign len           = GAP_W'(CAPACITY) - (gap_finish_ff - gap_begin_ff);
   assign pos_cmp       = CMP_W'(pos_ff);
   assign len_cmp       = CMP_W'(len);
   assign begin_cmp     = CMP_W'(gap_begin_ff);
   assign begin_dec     = gap_begin_ff - GAP_W'(1);
   assign finish_dec    = gap_finish_ff - GAP_W'(1);
   assign finish_at_end = (gap_finish_ff == GAP_W'(CAPACITY));

   // logical to physical index for reads
   assign read_idx = (pos_cmp < begin_cmp) ? pos_cmp
                   : pos_cmp - begin_cmp + CMP_W'(gap_finish_ff);

   // range check comes before the full check
   always_comb begin
      status_now = STATUS_OK;
      unique case (mode_ff)
         MODE_READ: begin
            if (pos_cmp >= len_cmp) status_now = STATUS_RANGE;
         end
         MODE_INSERT: begin
            priority if (pos_cmp > len_cmp) status_now = STATUS_RANGE;
            else if (len >= GAP_W'(CAPACITY)) status_now = STATUS_FULL;
         end
         MODE_DELETE: begin
            if (pos_cmp > len_cmp) status_now = STATUS_RANGE;
         end
         default: status_now = STATUS_OK;
      endcase
   end

   assign stat.mode       = mode_ff;
   assign stat.error      = (status_now != STATUS_OK);
   assign stat.need_left  = (pos_cmp < begin_cmp);
   assign stat.need_right = (pos_cmp > begin_cmp) && !finish_at_end;

   always_comb begin
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      gap_begin_in  = gap_begin_ff;
      gap_finish_in = gap_finish_ff;
      if (cmd.read) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = read_idx[ADDR_W-1:0];
      end
      if (cmd.move_read) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = stat.need_left ? begin_dec[ADDR_W-1:0] : gap_finish_ff[ADDR_W-1:0];
      end
      if (cmd.move_write) begin
         ram_wr_en   = 1'b1;
         ram_wr_data = ram_rd_data;
         if (stat.need_left) begin
            // byte left of the gap goes to its right edge
            ram_wr_addr   = finish_dec[ADDR_W-1:0];
            gap_begin_in  = begin_dec;
            gap_finish_in = finish_dec;
         end else begin
            ram_wr_addr   = gap_begin_ff[ADDR_W-1:0];
            gap_begin_in  = gap_begin_ff + GAP_W'(1);
            gap_finish_in = gap_finish_ff + GAP_W'(1);
         end
      end
      if (cmd.edit) begin
         if (mode_ff == MODE_INSERT) begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = gap_begin_ff[ADDR_W-1:0];
            ram_wr_data  = char_ff;
            gap_begin_in = gap_begin_ff + GAP_W'(1);
         end else if (!finish_at_end) begin
            gap_finish_in = gap_finish_ff + GAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_begin_ff  <= '0;
         gap_finish_ff <= GAP_W'(CAPACITY);
         rsp_valid_ff  <= 1'b0;
      end else begin
         gap_begin_ff  <= gap_begin_in;
         gap_finish_ff <= gap_finish_in;
         rsp_valid_ff  <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         char_ff <= req_char_in;
      end
      if (cmd.decide) begin
         status_hold_ff <= status_now;
      end
      if (cmd.respond) begin
         rsp_status_ff <= status_hold_ff;
         rsp_length_ff <= POS_W'(len);
         rsp_char_ff   <= (mode_ff == MODE_READ && status_hold_ff == STATUS_OK)
                          ? ram_rd_data : '0;
      end
   end

   gbts_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_text_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

[hw/rtl/gap_buffer_text_store_unit.sv]
// sequence: a read passes the decide, read and respond states before rsp_valid; an error or an unused mode
//   goes from decide straight to respond; insert/delete pass move and shift for each byte the gap moves, then edit
// throughput: one request at a time, busy drops in the cycle rsp_valid is high, so the next
//   request can be accepted at the edge that ends the strobe; each gap step costs a read
//   then a write on the single-port-pair text ram
// reset: synchronous active high; empty buffer, gap spans the whole store,
//   no clearing pass; rsp_valid is a one-cycle strobe, the receiver cannot stall
module gap_buffer_text_store_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [gbts_pkg::MODE_W-1:0]     req_mode,
   input  logic [gbts_pkg::POS_W-1:0]      req_position,
   input  logic [gbts_pkg::CHAR_W-1:0]     req_char_in,
   output logic                            rsp_valid,
   output logic [gbts_pkg::CHAR_W-1:0]     rsp_char_out,
   output logic [gbts_pkg::POS_W-1:0]      rsp_length,
   output logic [gbts_pkg::STATUS_W-1:0]   rsp_status
);
   import gbts_pkg::*;

   // command and status between sequencer and datapath
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer: accept, check, gap move loop, edit, respond
   gbts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath: request latch, gap pointers, text ram, response registers
   gbts_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_length   (rsp_length),
      .rsp_status   (rsp_status)
   );

endmodule

[hw/rtl/gbts_checker.sv]
module gbts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [gbts_pkg::CHAR_W-1:0]     rsp_char_out,
   input logic [gbts_pkg::STATUS_W-1:0]   rsp_status
);
   import gbts_pkg::*;

   // accepted request keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted request");

   // response strobe lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // finishing a request always gives a response
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // no response while a request is still in progress
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // failed requests return a zero byte
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_RANGE)
      |-> rsp_char_out == '0)
      else $error("nonzero byte on failed request");

endmodule

bind gap_buffer_text_store_unit gbts_checker u_gbts_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_char_out (rsp_char_out),
   .rsp_status   (rsp_status)
);
